// File: rtl/core/rdq_pkg.sv
// Package for the ring deque with cursor: operation and status codes,
// and the default sizes handed to the top level.
// No dependencies.
package rdq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Fixed widths of the transaction fields.
    localparam int OP_W     = 3;
    localparam int IO_W     = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK    = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT    = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK     = 3'd3;
    localparam logic [OP_W-1:0] OP_CURSOR_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_CURSOR_BACK  = 3'd5;
    localparam logic [OP_W-1:0] OP_NEXT         = 3'd6;
    localparam logic [OP_W-1:0] OP_PREV         = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// File: rtl/core/rdq_ram.sv
// Slot storage for the ring deque: one write port and one read port with
// registered read data.
// No dependencies.
module rdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ring_deque_with_cursor_unit.sv
// Top level of the ring deque with browsing cursor.
// Depends on rdq_pkg and rdq_ram.

// The block takes one operation transaction per clock cycle while req_stall
// is low and returns one result transaction for each in the cycle after
// acceptance; throughput is set by the single write and single read port of
// the slot memory, which every operation touches at most once. The pointers,
// count and cursor are updated at the acceptance edge, and the popped or
// browsed word comes out of the registered read port. A new request is taken
// whenever the result register is empty or is being taken in the same cycle.
// Slots hold words of DATA_WIDTH bits, capped at 32; a slot that was never
// written has no defined contents, and no reset pass runs over the memory.
module ring_deque_with_cursor_unit #(
    parameter int DEPTH      = rdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [rdq_pkg::OP_W-1:0]        operation,
    input  logic [rdq_pkg::IO_W-1:0]        value,

    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [rdq_pkg::IO_W-1:0]        data,
    output logic [rdq_pkg::STATUS_W-1:0]    status,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (DATA_WIDTH < rdq_pkg::IO_W) ? DATA_WIDTH : rdq_pkg::IO_W;

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [IW-1:0] front_reg, front_next;
    logic [IW-1:0] back_reg, back_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [IW-1:0] cursor_reg, cursor_next;
    logic          cursor_valid_reg, cursor_valid_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic [rdq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]                count_reg;
    logic                         take_reg, take_next;

    logic          accept;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [SW-1:0] rd_data;
    logic          is_empty;
    logic          is_full;
    logic          at_front;
    logic [IW-1:0] end_pos;

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x);
        ring_inc = (x == LAST_IDX) ? '0 : IW'(x + 1'b1);
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] x);
        ring_dec = (x == '0) ? LAST_IDX : IW'(x - 1'b1);
    endfunction

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == FULL_CNT);
    // Bit zero set selects the back end of the push, pop and cursor pairs.
    assign at_front = !operation[0];
    assign end_pos  = at_front ? front_reg : back_reg;

    always_comb
    begin
        front_next        = front_reg;
        back_next         = back_reg;
        fill_next         = fill_reg;
        cursor_next       = cursor_reg;
        cursor_valid_next = cursor_valid_reg;
        status_next       = rdq_pkg::ST_OK;
        take_next         = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = end_pos;
        rd_en             = 1'b0;
        rd_addr           = end_pos;

        unique case (operation)
            rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = rdq_pkg::ST_FULL;
                end
                else if (is_empty)
                begin
                    // The first entry lands on the chosen end and both ends meet there.
                    wr_en      = accept;
                    front_next = end_pos;
                    back_next  = end_pos;
                    fill_next  = CW'(1);
                end
                else
                begin
                    wr_en     = accept;
                    fill_next = fill_reg + 1'b1;
                    if (at_front)
                    begin
                        front_next = ring_dec(front_reg);
                        wr_addr    = front_next;
                    end
                    else
                    begin
                        back_next = ring_inc(back_reg);
                        wr_addr   = back_next;
                    end
                end
            end
            rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = rdq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en     = accept;
                    take_next = 1'b1;
                    fill_next = fill_reg - 1'b1;
                    if (cursor_valid_reg && (cursor_reg == end_pos))
                    begin
                        cursor_valid_next = 1'b0;
                    end
                    if (at_front)
                    begin
                        front_next = ring_inc(front_reg);
                    end
                    else
                    begin
                        back_next = ring_dec(back_reg);
                    end
                end
            end
            rdq_pkg::OP_CURSOR_FRONT, rdq_pkg::OP_CURSOR_BACK:
            begin
                if (is_empty)
                begin
                    cursor_valid_next = 1'b0;
                    status_next       = rdq_pkg::ST_EMPTY;
                end
                else
                begin
                    cursor_next       = end_pos;
                    cursor_valid_next = 1'b1;
                end
            end
            rdq_pkg::OP_NEXT, rdq_pkg::OP_PREV:
            begin
                if (!cursor_valid_reg)
                begin
                    status_next = rdq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en     = accept;
                    rd_addr   = cursor_reg;
                    take_next = 1'b1;
                    // Stepping off either end drops the cursor rather than wrapping.
                    if (at_front)
                    begin
                        if (cursor_reg == back_reg)
                        begin
                            cursor_valid_next = 1'b0;
                        end
                        else
                        begin
                            cursor_next = ring_inc(cursor_reg);
                        end
                    end
                    else
                    begin
                        if (cursor_reg == front_reg)
                        begin
                            cursor_valid_next = 1'b0;
                        end
                        else
                        begin
                            cursor_next = ring_dec(cursor_reg);
                        end
                    end
                end
            end
            default:
            begin
                status_next = rdq_pkg::ST_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    rdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value[SW-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg        <= '0;
            back_reg         <= '0;
            fill_reg         <= '0;
            cursor_reg       <= '0;
            cursor_valid_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                front_reg        <= front_next;
                back_reg         <= back_next;
                fill_reg         <= fill_next;
                cursor_reg       <= cursor_next;
                cursor_valid_reg <= cursor_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            count_reg  <= fill_next;
            take_reg   <= take_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign data      = take_reg ? rdq_pkg::IO_W'(rd_data) : '0;

endmodule
